### sv/ipv4dq_pkg.sv
// Package for the dotted-quad IPv4 parser: transaction types, character
// codes and the octet merge helper. No dependencies.
package ipv4dq_pkg;

    localparam logic [7:0]  CH_ZERO     = 8'h30;  // '0'
    localparam logic [7:0]  CH_NINE     = 8'h39;  // '9'
    localparam logic [7:0]  CH_DOT      = 8'h2E;  // '.'
    localparam logic [31:0] ADDR_ONES   = 32'hFFFF_FFFF;
    localparam logic [9:0]  OCTET_MAX   = 10'd255;
    localparam logic [1:0]  LAST_OCTET  = 2'd3;
    localparam logic [1:0]  MAX_DIGITS  = 2'd3;

    typedef struct packed {
        logic [7:0] character;
        logic       first;
    } t_item;

    typedef struct packed {
        logic [31:0] address;
        logic        failed;
    } t_result;

    typedef struct packed {
        logic active;   // parse running before this transaction
        logic emit;     // this transaction ends the parse
    } t_parse_stat;

    // AND the finished octet into its byte lane; other lanes untouched.
    function automatic logic [31:0] merge_octet(input logic [31:0] addr,
                                                input logic [1:0]  idx,
                                                input logic [7:0]  octet);
        logic [31:0] lane;
        lane = ADDR_ONES;
        case (idx)
            2'd0:    lane[7:0]   = octet;
            2'd1:    lane[15:8]  = octet;
            2'd2:    lane[23:16] = octet;
            default: lane[31:24] = octet;
        endcase
        return addr & lane;
    endfunction

endpackage

### sv/ipv4_dotted_quad_parser_unit.sv
// Top level of the streaming dotted-quad IPv4 parser.
// Depends on ipv4dq_pkg, ipv4dq_in_stage, ipv4dq_parse, ipv4dq_out_stage.
//
// Feed the characters of an address string one per transaction, with
// i_in_first set on the first character of each string; that character
// restarts the parse and is itself parsed. Each octet takes one to three
// decimal digits and must not exceed 255; after octets 0 to 2 the first
// non-digit must be '.', after octet 3 any non-digit (a NUL, say) ends the
// string. When the parse ends, one result transaction is sent: the address
// with octet 0 in bits 7:0 and unfilled lanes all ones, and o_out_failed set
// on a syntax or range error (the failing octet is not merged). Characters
// after that are dropped until the next flagged first. A string that never
// terminates gives no result. Throughput is one character per clock but for
// the stall named below; a character passes through the input register,
// then through the parse step (a x10 shift-add, a compare against 255 and a
// byte-lane merge) into the result register. The only loop is the parse
// state feeding back on itself each character. The input stalls only while
// a finished result is held and the receiver stalls.
module ipv4_dotted_quad_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_character,
    input  logic        i_in_first,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_out_address,
    output logic        o_out_failed
);
    import ipv4dq_pkg::*;

    t_item       w_in_item;
    t_item       w_item;
    logic        w_item_valid;
    logic        w_can_load;
    logic        w_fire;
    t_result     w_result;
    t_result     w_out_result;
    t_parse_stat w_stat;

    assign w_in_item.character = i_in_character;
    assign w_in_item.first     = i_in_first;

    // The parse step runs whenever a character is held and the result
    // register can absorb a possible result this cycle.
    assign w_fire = w_item_valid && w_can_load;

    ipv4dq_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_take  (w_fire),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    ipv4dq_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_result (w_result),
        .o_stat   (w_stat)
    );

    ipv4dq_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire && w_stat.emit),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_result   (w_out_result)
    );

    assign o_out_address = w_out_result.address;
    assign o_out_failed  = w_out_result.failed;

    // A result from the parse step always lands in the result register.
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_stat.emit) |=> o_out_valid)
        else $error("parse result not captured");

    // Idle and not a first character: nothing may be emitted.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_item.first && !w_stat.active) |-> !w_stat.emit)
        else $error("result emitted while idle");

    // A held character that cannot advance is not lost.
    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_valid && !w_can_load) |=> (w_item_valid && $stable(w_item)))
        else $error("held character dropped or changed");

    // Result register only goes valid through a parse step that emits.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !(w_fire && w_stat.emit)) |=> !o_out_valid)
        else $error("result appeared without a parse step");

endmodule

### sv/ipv4dq_in_stage.sv
// Input register of the dotted-quad parser. Holds one character
// transaction until the parse stage takes it. Uses ipv4dq_pkg.
module ipv4dq_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ipv4dq_pkg::t_item  i_item,
    input  logic               i_take,      // parse stage consumes the held item
    output logic               o_valid,
    output ipv4dq_pkg::t_item  o_item
);
    import ipv4dq_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/ipv4dq_parse.sv
// Parse stage of the dotted-quad parser: octet index, digit count,
// decimal accumulator and address under construction. Uses ipv4dq_pkg.
module ipv4dq_parse (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  ipv4dq_pkg::t_item       i_item,
    output ipv4dq_pkg::t_result     o_result,
    output ipv4dq_pkg::t_parse_stat o_stat
);
    import ipv4dq_pkg::*;

    logic [1:0]  r_idx, n_idx;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_acc, n_acc;
    logic [31:0] r_addr, n_addr;
    logic        r_active, n_active;

    logic [1:0]  w_idx, w_cnt;
    logic [9:0]  w_acc;
    logic [31:0] w_addr;
    logic        w_act;
    logic        w_digit;
    logic [13:0] w_acc10;
    logic        w_emit, w_fail;

    // Restart on a flagged first character, then step.
    always_comb begin
        w_idx  = r_idx;
        w_cnt  = r_cnt;
        w_acc  = r_acc;
        w_addr = r_addr;
        w_act  = r_active;
        if (i_item.first) begin
            w_idx  = '0;
            w_cnt  = '0;
            w_acc  = '0;
            w_addr = ADDR_ONES;
            w_act  = 1'b1;
        end
    end

    assign w_digit = (i_item.character >= CH_ZERO) && (i_item.character <= CH_NINE);
    // acc * 10 as shift-add, plus the digit value
    assign w_acc10 = {1'b0, w_acc, 3'b000} + {3'b000, w_acc, 1'b0}
                   + {10'd0, i_item.character[3:0]};

    always_comb begin
        n_idx    = w_idx;
        n_cnt    = w_cnt;
        n_acc    = w_acc;
        n_addr   = w_addr;
        n_active = w_act;
        w_emit   = 1'b0;
        w_fail   = 1'b0;
        if (w_act) begin
            if (w_digit) begin
                if (w_cnt >= MAX_DIGITS) begin
                    w_emit = 1'b1;
                    w_fail = 1'b1;
                end else begin
                    n_acc = w_acc10[9:0];
                    n_cnt = w_cnt + 2'd1;
                end
            end else if (w_cnt == 2'd0 || w_acc > OCTET_MAX ||
                         (w_idx != LAST_OCTET && i_item.character != CH_DOT)) begin
                w_emit = 1'b1;
                w_fail = 1'b1;
            end else begin
                n_addr = merge_octet(w_addr, w_idx, w_acc[7:0]);
                if (w_idx == LAST_OCTET) begin
                    w_emit = 1'b1;
                end else begin
                    n_idx = w_idx + 2'd1;
                    n_cnt = '0;
                    n_acc = '0;
                end
            end
            if (w_emit) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_addr   <= ADDR_ONES;
        end else if (i_fire) begin
            r_active <= n_active;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_addr   <= n_addr;
        end
    end

    // Failures report the address before the failing octet; success after merge.
    assign o_result.address = n_addr;
    assign o_result.failed  = w_fail;
    assign o_stat.active    = r_active;
    assign o_stat.emit      = w_emit;

endmodule

### sv/ipv4dq_out_stage.sv
// Result register of the dotted-quad parser. Holds one result transaction
// until the receiver takes it. Uses ipv4dq_pkg.
module ipv4dq_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ipv4dq_pkg::t_result i_result,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_stall,
    output ipv4dq_pkg::t_result o_result
);
    import ipv4dq_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_can_load = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### sim/ipv4dq_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the dotted-quad IPv4 parser: watches both channels, predicts each
// parse result from the accepted characters and compares. Depends on ipv4dq_pkg.
module ipv4dq_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_character,
    input  logic        i_in_first,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_out_address,
    input  logic        i_out_failed,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_failed_results
);
    import ipv4dq_pkg::*;

    // predicted parse state
    logic [1:0]  quad_idx;
    logic [1:0]  ndigits;
    logic [9:0]  octet_val;
    logic [31:0] addr_model;
    logic        parsing;

    t_result awaited_results[$];

    int fail_cnt    = 0;
    int pending_cnt = 0;
    int result_cnt  = 0;
    int failed_cnt  = 0;

    assign o_errors         = fail_cnt;
    assign o_pending        = pending_cnt;
    assign o_results        = result_cnt;
    assign o_failed_results = failed_cnt;

    task automatic clear_parse();
        quad_idx   = '0;
        ndigits    = '0;
        octet_val  = '0;
        addr_model = ADDR_ONES;
    endtask

    // Advance the parse by one accepted character; queue a result when it ends.
    task automatic predict_parse(input logic [7:0] ch, input logic first);
        logic        done;
        logic        bad;
        logic [4:0]  shift;
        logic [31:0] lane;
        t_result     res;
        done = 1'b0;
        bad  = 1'b0;
        if (first) begin
            clear_parse();
            parsing = 1'b1;
        end
        if (!parsing)
            return;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (ndigits == MAX_DIGITS) begin
                done = 1'b1;
                bad  = 1'b1;
            end else begin
                octet_val = 10'(octet_val * 10 + (ch - CH_ZERO));
                ndigits   = ndigits + 2'd1;
            end
        end else if (ndigits == '0 || octet_val > OCTET_MAX ||
                     (quad_idx != LAST_OCTET && ch != CH_DOT)) begin
            done = 1'b1;
            bad  = 1'b1;
        end else begin
            shift      = {quad_idx, 3'b000};
            lane       = ~(32'h0000_00FF << shift) | ({24'h0, octet_val[7:0]} << shift);
            addr_model = addr_model & lane;
            if (quad_idx == LAST_OCTET) begin
                done = 1'b1;
            end else begin
                quad_idx  = quad_idx + 2'd1;
                ndigits   = '0;
                octet_val = '0;
            end
        end
        if (done) begin
            res.address = addr_model;
            res.failed  = bad;
            awaited_results.push_back(res);
            parsing = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_parse();
            parsing = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: address %h failed %b",
                           i_out_address, i_out_failed);
                    fail_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_address !== want.address) begin
                        $error("address mismatch: expected %h, actual %h",
                               want.address, i_out_address);
                        fail_cnt++;
                    end
                    if (i_out_failed !== want.failed) begin
                        $error("failed mismatch: expected %b, actual %b",
                               want.failed, i_out_failed);
                        fail_cnt++;
                    end
                    result_cnt++;
                    if (want.failed)
                        failed_cnt++;
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_parse(i_in_character, i_in_first);
        end
        pending_cnt = awaited_results.size();
    end

endmodule

### sim/ipv4_dotted_quad_parser_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for ipv4_dotted_quad_parser_unit: drives character transactions and
// random output stalls, gives the verdict. Depends on ipv4dq_pkg and ipv4dq_scoreboard.
module ipv4_dotted_quad_parser_unit_tb;
    import ipv4dq_pkg::*;

    localparam int         RANDOM_CHARS = 1870;  // address-string characters, all phases
    localparam int         STALL_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int         DRAIN_CYCLES = 8;     // drain margin after the last result
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TOP       = 8'hFF;

    // Handshake phases: sender idle and receiver stall odds, percent per cycle.
    localparam int TX_IDLE_PCT[4]  = '{0, 87, 0, 23};
    localparam int RX_STALL_PCT[4] = '{0, 0, 87, 23};

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  in_character = '0;
    logic        in_first     = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [31:0] out_address;
    logic        out_failed;

    int err_cnt;
    int pending;
    int results;
    int failed_results;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int chars_total  = 0;   // every accepted character
    int chars_parsed = 0;   // characters of random address strings
    int stuck_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ipv4_dotted_quad_parser_unit i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_character (in_character),
        .i_in_first     (in_first),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_address  (out_address),
        .o_out_failed   (out_failed)
    );

    ipv4dq_scoreboard i_scoreboard (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_character   (in_character),
        .i_in_first       (in_first),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_address    (out_address),
        .i_out_failed     (out_failed),
        .o_errors         (err_cnt),
        .o_pending        (pending),
        .o_results        (results),
        .o_failed_results (failed_results)
    );

    // Receiver back-pressure: one fresh draw per cycle.
    always @(posedge clk) begin
        out_stall <= (rx_stall_pct != 0) && ($urandom_range(99, 0) < rx_stall_pct);
    end

    // Watchdog: counts cycles in which neither channel moves a transaction.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STALL_LIMIT);
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("ipv4_dotted_quad_parser_unit_tb: done, errors");
        $finish;
    end

    // One character transaction. Optional idle cycles come first (valid low);
    // returns at the edge that accepts it, with valid still high so the next
    // call can keep the bus busy without a low/high pair in one step.
    task automatic send_char(input logic [7:0] ch, input logic first);
        while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_character <= ch;
        in_first     <= first;
        do @(posedge clk); while (in_stall);
        chars_total++;
    endtask

    // A string whose first character carries the restart flag.
    task automatic send_word(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == 0);
    endtask

    initial begin
        logic [7:0] txt[$];
        logic [7:0] ch;
        int         nd;
        int         val;
        int         cut;
        int         n;
        int         digs[4];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: every way a parse can end, no idling ---
        send_char("x", 1'b0);       // idle after reset, no restart flag: dropped
        send_char(CH_DOT, 1'b1);    // separator with no digits
        send_word("1234");          // fourth digit in an octet
        send_word("256.");          // octet above 255
        send_word("7.9:");          // wrong separator, octet 0 already merged
        send_word("1.2");           // never terminated, restarted by the next string
        send_word("0.0.0.255");     // extreme octet values, clean parse
        send_char(CH_TOP, 1'b0);    // terminator with every bit set

        // --- random: mostly well-formed strings with random content ---
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = TX_IDLE_PCT[ph];
            rx_stall_pct = RX_STALL_PCT[ph];
            while (chars_parsed < (ph + 1) * RANDOM_CHARS / 4) begin
                if ($urandom_range(99, 0) < 8) begin
                    // noise: raw bytes, restart flag at random
                    n = $urandom_range(4, 1);
                    repeat (n)
                        send_char(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
                end else begin
                    txt.delete();
                    for (int oct = 0; oct < 4; oct++) begin
                        n  = $urandom_range(99, 0);
                        nd = (n < 3) ? 0 : (n < 6) ? 4 : $urandom_range(3, 1);
                        if (nd == 4)
                            val = $urandom_range(9999, 0);
                        else if (nd == 3 && $urandom_range(19, 0) == 0)
                            val = $urandom_range(999, 256);   // out of range
                        else
                            val = $urandom_range(nd == 1 ? 9 : nd == 2 ? 99 : 255, 0);
                        // short values in a three-digit slot get leading zeros
                        for (int d = 0; d < nd; d++) begin
                            digs[d] = val % 10;
                            val     = val / 10;
                        end
                        for (int d = nd - 1; d >= 0; d--)
                            txt.push_back(CH_ZERO + 8'(digs[d]));
                        if (oct < 3) begin
                            if ($urandom_range(29, 0) == 0)
                                txt.push_back(8'($urandom_range(255, 0)));
                            else
                                txt.push_back(CH_DOT);
                        end else if ($urandom_range(2, 0) == 0) begin
                            txt.push_back(CH_NUL);
                        end else begin
                            do ch = 8'($urandom_range(255, 0));
                            while (ch >= CH_ZERO && ch <= CH_NINE);
                            txt.push_back(ch);
                        end
                    end
                    // now and then the string stops short
                    if ($urandom_range(19, 0) == 0) begin
                        cut = $urandom_range(txt.size() - 1, 1);
                        while (txt.size() > cut)
                            void'(txt.pop_back());
                    end
                    foreach (txt[i])
                        send_char(txt[i], i == 0);
                    chars_parsed += txt.size();
                    // trailing bytes without the restart flag
                    if ($urandom_range(4, 0) == 0) begin
                        n = $urandom_range(3, 1);
                        repeat (n)
                            send_char(8'($urandom_range(255, 0)), 1'b0);
                    end
                end
            end
            // let the phase settle before the odds change
            do @(posedge clk); while (pending != 0);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0)
            $error("%0d expected parse results never arrived", pending);

        $display("%0d characters sent, %0d of them in random address strings",
                 chars_total, chars_parsed);
        $display("%0d parse results compared, %0d flagged failed, over 4 handshake phases",
                 results, failed_results);
        if (err_cnt == 0 && pending == 0)
            $display("ipv4_dotted_quad_parser_unit_tb: done, clean");
        else
            $display("ipv4_dotted_quad_parser_unit_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
sv/ipv4dq_pkg.sv
sv/ipv4dq_in_stage.sv
sv/ipv4dq_parse.sv
sv/ipv4dq_out_stage.sv
sv/ipv4_dotted_quad_parser_unit.sv
sim/ipv4dq_scoreboard.sv
sim/ipv4_dotted_quad_parser_unit_tb.sv
